// File: rtl/cpdth_pkg.sv
// Shared types and constants for the channel-pair delta-time histogram.
// No dependencies; every other file in this block but cpdth_fifo imports this package.
`default_nettype none

package cpdth_pkg;

    // Field widths fixed by the interface.
    localparam int TIME_W   = 29;
    localparam int COARSE_W = 16;
    localparam int FINE_W   = 16;
    localparam int FINE_P_W = 25;
    localparam int CH_IN_W  = 5;
    localparam int IDX_IN_W = 10;
    localparam int DNS_W    = 19;
    localparam int COUNT_W  = 32;

    // Time scale of the TDC counts.
    localparam logic [12:0] PS_PER_COARSE = 13'd5000;
    localparam logic [8:0]  PS_PER_FINE   = 9'd300;
    localparam logic [9:0]  PS_PER_NS     = 10'd1000;

    // Division by 1000 as multiply by floor(2^38 / 1000), then one correction step.
    localparam int          Q_W         = 20;
    localparam int          RECIP_SHIFT = 38;
    localparam logic [28:0] RECIP_1000  = 29'd274877906;

    // Largest difference two valid slot times can produce, in ns.
    localparam logic [DNS_W-1:0] MAX_DELTA_NS = 19'd347335;

    // Queue depths between the parts of the block.
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    // What the back part has to do with one item.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_READ  = 2'd1,
        OP_DELTA = 2'd2
    } op_kind_t;

    typedef struct packed {
        logic               delta_valid;
        logic [DNS_W-1:0]   delta_ns;
        logic [COUNT_W-1:0] bin_count;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/channel_pair_delta_time_histogram.sv
// Throughput: one item per cycle while full stays low, set by the histogram counter port
// (one read, one write). Reset: asynchronous, active low; slots empty, then a clearing
// pass zeroes every counter while full stays high. Top level; depends on cpdth_pkg,
// cpdth_front, cpdth_fifo and cpdth_back.
`default_nettype none

module channel_pair_delta_time_histogram import cpdth_pkg::*; #(
    parameter int NUM_CHANNELS = 19,
    parameter int NUM_BINS     = 1000
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  cmd,
    input  wire logic [CH_IN_W-1:0]    channel,
    input  wire logic [COARSE_W-1:0]   coarse_time,
    input  wire logic [FINE_W-1:0]     fine_time,
    input  wire logic [IDX_IN_W-1:0]   bin_index,
    output logic                       empty,
    input  wire logic                  pop,
    output logic                       delta_valid,
    output logic [DNS_W-1:0]           delta_ns,
    output logic [COUNT_W-1:0]         bin_count
);

    // Each queued operation carries its kind, the two slot times and a bin number.
    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int OP_W  = 2 + 2 * TIME_W + BIN_W;

    logic                           op_push;
    logic [OP_W-1:0]                op_wdata;
    logic [OP_W-1:0]                op_rdata;
    logic                           op_empty;
    logic                           op_pop;
    logic [$clog2(MID_DEPTH+1)-1:0] op_level;

    logic                           res_push;
    result_t                        res_wdata;
    result_t                        res_rdata;
    logic [$clog2(OUT_DEPTH+1)-1:0] res_level;
    logic                           clr_busy;

    // The front part forms the hit time, updates the channel slots in order and
    // decides whether an item is a bin read, a delta, or produces an empty result.
    // It never stalls internally; it refuses new items during the clearing pass and
    // when the operation queue could not hold everything already in its two stages.
    cpdth_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_BINS     (NUM_BINS),
        .DEPTH        (MID_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .channel     (channel),
        .coarse_time (coarse_time),
        .fine_time   (fine_time),
        .bin_index   (bin_index),
        .clr_busy    (clr_busy),
        .fifo_level  (op_level),
        .op_push     (op_push),
        .op_data     (op_wdata)
    );

    // Operation queue that decouples classification from the histogram work.
    cpdth_fifo #(
        .WIDTH (OP_W),
        .DEPTH (MID_DEPTH)
    ) u_op_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .din   (op_wdata),
        .pop   (op_pop),
        .dout  (op_rdata),
        .empty (op_empty),
        .level (op_level)
    );

    // The back part turns the slot times into nanoseconds, updates the bin
    // counter and builds the result. It takes an operation only when the
    // result queue is sure to have room for it.
    cpdth_back #(
        .NUM_BINS (NUM_BINS),
        .DEPTH    (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_empty  (op_empty),
        .op_data   (op_rdata),
        .op_pop    (op_pop),
        .out_level (res_level),
        .res_push  (res_push),
        .res_data  (res_wdata),
        .clr_busy  (clr_busy)
    );

    // Result queue: results that are not popped can fill it and then hold off new items.
    cpdth_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_wdata),
        .pop   (pop),
        .dout  (res_rdata),
        .empty (empty),
        .level (res_level)
    );

    assign delta_valid = res_rdata.delta_valid;
    assign delta_ns    = res_rdata.delta_ns;
    assign bin_count   = res_rdata.bin_count;

endmodule

`default_nettype wire

// File: rtl/cpdth_fifo.sv
// Small first-in first-out queue of registers with a fill level output.
// Generic; used between front and back and in front of the result ports.
`default_nettype none

module cpdth_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire logic [WIDTH-1:0]             din,
    input  wire logic                         pop,
    output logic      [WIDTH-1:0]             dout,
    output logic                              empty,
    output logic      [$clog2(DEPTH+1)-1:0]   level
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_push;
    logic             do_pop;

    assign do_push = push && (level_reg != LVL_W'(DEPTH));
    assign do_pop  = pop && (level_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + LVL_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - LVL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    assign dout  = mem[rd_ptr_reg];
    assign empty = (level_reg == '0);
    assign level = level_reg;

endmodule

`default_nettype wire

// File: rtl/cpdth_front.sv
// Front part: accepts items, forms hit times, owns the per-channel time slots
// and classifies each item for the back part. Depends on cpdth_pkg.
`default_nettype none

module cpdth_front import cpdth_pkg::*; #(
    parameter int NUM_CHANNELS = 19,
    parameter int NUM_BINS     = 1000,
    parameter int DEPTH        = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              cmd,
    input  wire logic [CH_IN_W-1:0]                channel,
    input  wire logic [COARSE_W-1:0]               coarse_time,
    input  wire logic [FINE_W-1:0]                 fine_time,
    input  wire logic [IDX_IN_W-1:0]               bin_index,
    input  wire logic                              clr_busy,
    input  wire logic [$clog2(DEPTH+1)-1:0]        fifo_level,
    output logic                                   op_push,
    output logic [2+2*TIME_W+$clog2(NUM_BINS)-1:0] op_data
);

    localparam int CH_W  = $clog2(NUM_CHANNELS);
    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int LW    = $clog2(DEPTH + 1) + 1;

    // Stage 1: products of the accepted hit.
    logic                  s1_v_reg;
    logic                  s1_cmd_reg;
    logic [CH_IN_W-1:0]    s1_ch_reg;
    logic [IDX_IN_W-1:0]   s1_idx_reg;
    logic [TIME_W-1:0]     s1_p1_reg;
    logic [FINE_P_W-1:0]   s1_p2_reg;

    // Stage 2: classified item and the slot times read for it.
    logic                  s2_v_reg;
    op_kind_t              s2_kind_reg;
    logic [BIN_W-1:0]      s2_bin_reg;
    logic [TIME_W-1:0]     rd_a_reg;
    logic [TIME_W-1:0]     rd_b_reg;

    logic [NUM_CHANNELS-1:0] slot_v_reg, slot_v_next;
    logic [TIME_W-1:0]       slot_mem [NUM_CHANNELS];

    logic              accept;
    logic [LW-1:0]     in_flight;
    logic              ch_ok;
    logic              idx_ok;
    logic [CH_W-1:0]   ch_idx;
    logic [CH_W-1:0]   ch_lo;
    logic [TIME_W-1:0] hit_time;
    logic              cur_v;
    logic              lo_v;
    logic              do_store;
    logic              do_delta;
    op_kind_t          kind;

    // Admission counts the items already in stages 1 and 2 against queue room.
    assign in_flight = LW'(fifo_level) + LW'(s1_v_reg) + LW'(s2_v_reg);
    assign full      = clr_busy || (in_flight >= LW'(DEPTH));
    assign accept    = push && !full;

    assign ch_ok    = {2'b00, s1_ch_reg} < 7'(NUM_CHANNELS);
    assign idx_ok   = {3'b000, s1_idx_reg} < 13'(NUM_BINS);
    assign ch_idx   = ch_ok ? CH_W'(s1_ch_reg) : '0;
    assign ch_lo    = (ch_idx == '0) ? '0 : ch_idx - CH_W'(1);
    assign hit_time = s1_p1_reg + TIME_W'(s1_p2_reg);
    assign cur_v    = slot_v_reg[ch_idx];
    assign lo_v     = slot_v_reg[ch_lo];

    always_comb
    begin
        kind     = OP_NONE;
        do_store = 1'b0;
        do_delta = 1'b0;
        priority if (s1_cmd_reg)
        begin
            kind = idx_ok ? OP_READ : OP_NONE;
        end
        else if (!ch_ok)
        begin
            kind = OP_NONE;
        end
        else if (!cur_v)
        begin
            // A hit at time zero leaves the slot empty.
            do_store = (hit_time != '0);
        end
        else if ((s1_ch_reg != '0) && lo_v)
        begin
            kind     = OP_DELTA;
            do_delta = 1'b1;
        end
        else
        begin
            // A full slot without a full lower neighbor changes nothing.
            kind = OP_NONE;
        end
    end

    always_comb
    begin
        slot_v_next = slot_v_reg;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (s1_v_reg && do_store && (ch_idx == CH_W'(i)))
            begin
                slot_v_next[i] = 1'b1;
            end
            if (s1_v_reg && do_delta && ((ch_idx == CH_W'(i)) || (ch_lo == CH_W'(i))))
            begin
                slot_v_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            slot_v_reg <= '0;
        end
        else
        begin
            s1_v_reg   <= accept;
            s2_v_reg   <= s1_v_reg;
            slot_v_reg <= slot_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= cmd;
            s1_ch_reg  <= channel;
            s1_idx_reg <= bin_index;
            s1_p1_reg  <= TIME_W'(coarse_time) * TIME_W'(PS_PER_COARSE);
            s1_p2_reg  <= FINE_P_W'(fine_time) * FINE_P_W'(PS_PER_FINE);
        end
        if (s1_v_reg)
        begin
            s2_kind_reg <= kind;
            s2_bin_reg  <= BIN_W'(s1_idx_reg);
        end
    end

    // Slot time store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (s1_v_reg && do_store)
        begin
            slot_mem[ch_idx] <= hit_time;
        end
        if (s1_v_reg)
        begin
            rd_a_reg <= slot_mem[ch_idx];
            rd_b_reg <= slot_mem[ch_lo];
        end
    end

    assign op_push = s2_v_reg;
    assign op_data = {s2_kind_reg, rd_a_reg, rd_b_reg, s2_bin_reg};

endmodule

`default_nettype wire

// File: rtl/cpdth_back.sv
// Back part: time difference, conversion to ns, bin selection and the histogram
// counter read-modify-write, plus the clearing pass after reset. Depends on cpdth_pkg.
`default_nettype none

module cpdth_back import cpdth_pkg::*; #(
    parameter int NUM_BINS = 1000,
    parameter int DEPTH    = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              op_empty,
    input  wire logic [2+2*TIME_W+$clog2(NUM_BINS)-1:0] op_data,
    output logic                                   op_pop,
    input  wire logic [$clog2(DEPTH+1)-1:0]        out_level,
    output logic                                   res_push,
    output result_t                                res_data,
    output logic                                   clr_busy
);

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int OP_W  = 2 + 2 * TIME_W + BIN_W;
    localparam int LW    = $clog2(DEPTH + 1) + 3;

    op_kind_t          op_kind;
    logic [TIME_W-1:0] op_a;
    logic [TIME_W-1:0] op_b;
    logic [BIN_W-1:0]  op_bin;
    logic              take;
    logic [LW-1:0]     committed;

    logic              b1_v_reg, b2_v_reg, b3_v_reg, b4_v_reg;
    op_kind_t          b1_kind_reg, b2_kind_reg, b3_kind_reg, b4_kind_reg;
    logic [BIN_W-1:0]  b1_bin_reg, b2_bin_reg, b3_bin_reg, b4_addr_reg;
    logic [TIME_W-1:0] b1_diff_reg, b2_diff_reg;
    logic [Q_W-1:0]    b2_q0_reg, b3_dns_reg, b4_dns_reg;

    logic [2*TIME_W-1:0] prod;
    logic [TIME_W:0]     q_times;
    logic [TIME_W:0]     rem;
    logic [Q_W-1:0]      dns;
    logic [BIN_W-1:0]    rd_addr;

    logic [COUNT_W-1:0] hist_mem [NUM_BINS];
    logic [COUNT_W-1:0] hist_q_reg;
    logic               fwd_v_reg;
    logic [BIN_W-1:0]   fwd_addr_reg;
    logic [COUNT_W-1:0] fwd_cnt_reg;
    logic [COUNT_W-1:0] cur_count;
    logic [COUNT_W-1:0] new_count;
    logic               inc_en;
    logic               wr_en;
    logic [BIN_W-1:0]   wr_addr;
    logic [COUNT_W-1:0] wr_data;

    logic               clr_busy_reg;
    logic [BIN_W-1:0]   clr_idx_reg;

    assign op_kind = op_kind_t'(op_data[OP_W-1 -: 2]);
    assign op_a    = op_data[BIN_W+2*TIME_W-1 -: TIME_W];
    assign op_b    = op_data[BIN_W+TIME_W-1 -: TIME_W];
    assign op_bin  = op_data[BIN_W-1:0];

    // Every item in the pipeline is guaranteed a place in the result queue.
    assign committed = LW'(out_level) + LW'(b1_v_reg) + LW'(b2_v_reg)
                     + LW'(b3_v_reg) + LW'(b4_v_reg);
    assign take      = !op_empty && !clr_busy_reg && (committed < LW'(DEPTH));
    assign op_pop    = take;

    // Stage 2 multiply, stage 3 correction of the quotient estimate.
    assign prod    = (2*TIME_W)'(b1_diff_reg) * (2*TIME_W)'(RECIP_1000);
    assign q_times = (TIME_W+1)'(b2_q0_reg) * (TIME_W+1)'(PS_PER_NS);
    assign rem     = (TIME_W+1)'(b2_diff_reg) - q_times;
    assign dns     = b2_q0_reg + Q_W'(rem >= (TIME_W+1)'(PS_PER_NS));

    // Large differences land in the overflow bin.
    always_comb
    begin
        rd_addr = b3_bin_reg;
        if (b3_kind_reg == OP_DELTA)
        begin
            rd_addr = (b3_dns_reg >= Q_W'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1)
                                                          : b3_dns_reg[BIN_W-1:0];
        end
    end

    // A counter written by the item just before may not have reached the read data yet.
    assign cur_count = (fwd_v_reg && (fwd_addr_reg == b4_addr_reg)) ? fwd_cnt_reg
                                                                   : hist_q_reg;
    assign new_count = (cur_count == '1) ? cur_count : cur_count + COUNT_W'(1);
    assign inc_en    = b4_v_reg && (b4_kind_reg == OP_DELTA);

    assign wr_en   = clr_busy_reg || inc_en;
    assign wr_addr = clr_busy_reg ? clr_idx_reg : b4_addr_reg;
    assign wr_data = clr_busy_reg ? '0 : new_count;

    always_comb
    begin
        res_data = '0;
        unique case (b4_kind_reg)
            OP_DELTA:
            begin
                res_data.delta_valid = 1'b1;
                res_data.delta_ns    = b4_dns_reg[DNS_W-1:0];
                res_data.bin_count   = new_count;
            end
            OP_READ:
            begin
                res_data.bin_count = cur_count;
            end
            OP_NONE:
            begin
                res_data = '0;
            end
            default:
            begin
                res_data = '0;
            end
        endcase
    end

    assign res_push = b4_v_reg;
    assign clr_busy = clr_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_v_reg     <= 1'b0;
            b2_v_reg     <= 1'b0;
            b3_v_reg     <= 1'b0;
            b4_v_reg     <= 1'b0;
            fwd_v_reg    <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            b1_v_reg <= take;
            b2_v_reg <= b1_v_reg;
            b3_v_reg <= b2_v_reg;
            b4_v_reg <= b3_v_reg;
            if (inc_en)
            begin
                fwd_v_reg <= 1'b1;
            end
            if (clr_busy_reg)
            begin
                if (clr_idx_reg == BIN_W'(NUM_BINS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
                else
                begin
                    clr_idx_reg <= clr_idx_reg + BIN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            b1_kind_reg <= op_kind;
            b1_bin_reg  <= op_bin;
            b1_diff_reg <= (op_a >= op_b) ? op_a - op_b : op_b - op_a;
        end
        if (b1_v_reg)
        begin
            b2_kind_reg <= b1_kind_reg;
            b2_bin_reg  <= b1_bin_reg;
            b2_diff_reg <= b1_diff_reg;
            b2_q0_reg   <= prod[RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
        end
        if (b2_v_reg)
        begin
            b3_kind_reg <= b2_kind_reg;
            b3_bin_reg  <= b2_bin_reg;
            b3_dns_reg  <= dns;
        end
        if (b3_v_reg)
        begin
            b4_kind_reg <= b3_kind_reg;
            b4_addr_reg <= rd_addr;
            b4_dns_reg  <= b3_dns_reg;
        end
        if (inc_en)
        begin
            fwd_addr_reg <= b4_addr_reg;
            fwd_cnt_reg  <= new_count;
        end
    end

    // Histogram counters: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (b3_v_reg)
        begin
            hist_q_reg <= hist_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/cpdth_checker.sv
// Port-level checks on the result channel of the delta-time histogram,
// bound to the top level. Depends on cpdth_pkg.
`default_nettype none

module cpdth_checker import cpdth_pkg::*; (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               empty,
    input wire logic               pop,
    input wire logic               delta_valid,
    input wire logic [DNS_W-1:0]   delta_ns,
    input wire logic [COUNT_W-1:0] bin_count
);

    // A delta has just incremented its bin, so the count it reports is never zero.
    a_delta_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && delta_valid) |-> (bin_count != '0))
        else $error("delta item reports a zero bin count");

    // Only a delta item carries a time difference.
    a_no_delta_zero_ns: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !delta_valid) |-> (delta_ns == '0))
        else $error("non-delta item carries a nonzero delta");

    // The difference of two slot times is bounded by the largest hit time.
    a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && delta_valid) |-> (delta_ns <= MAX_DELTA_NS))
        else $error("delta exceeds the largest possible hit time");

    // A waiting result stays on the ports until it is taken.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable({delta_valid, delta_ns, bin_count})))
        else $error("waiting result changed before it was taken");

endmodule

bind channel_pair_delta_time_histogram cpdth_checker u_cpdth_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .delta_valid (delta_valid),
    .delta_ns    (delta_ns),
    .bin_count   (bin_count)
);

`default_nettype wire
